>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on aclk, quiet during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define WPM_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("assertion failed");

`define WPM_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define WPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define WPM_ASSERT_ALWAYS(lbl, expr)
`define WPM_ASSERT_IMPLIES(lbl, ante, cons)
`define WPM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/wpm_pkg.sv
// ---------------------------------------------------------------------------
// wpm_pkg
// item kinds, wildcard codes and the control bundle shared by the match cells
// ---------------------------------------------------------------------------
package wpm_pkg;

    localparam int LEN_W = 6;

    localparam logic [7:0] STAR_BYTE = 8'd42;
    localparam logic [7:0] ANY_BYTE  = 8'd63;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_BEGIN  = 2'd2,
        KIND_TEXT   = 2'd3
    } wpm_kind_t;

    typedef struct packed {
        logic             load;
        logic             step;
        logic             wr;
        logic [LEN_W-1:0] len_cur;
        logic [LEN_W-1:0] len_next;
    } wpm_ctl_t;

endpackage

>>> hdl/wpm_cell.sv
// ---------------------------------------------------------------------------
// wpm_cell
// one pattern position: holds its pattern byte and its match bit, takes the
// leading-star and star-run ripples from its left neighbor
// ---------------------------------------------------------------------------
module wpm_cell
    import wpm_pkg::*;
#(
    parameter int INDEX = 1
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  wpm_ctl_t   ctl,
    input  logic [7:0] symbol,
    input  logic       lead_in,
    input  logic       row_in,
    input  logic       old_in,
    output logic       lead_out,
    output logic       row_out,
    output logic       old_out
);

    logic [7:0] pattern_reg;
    logic [7:0] pattern_next;
    logic       bit_reg;
    logic       bit_next;
    logic       write_en;
    logic       active;
    logic       adv;

    assign write_en     = ctl.wr && (ctl.len_cur == LEN_W'(INDEX - 1));
    assign pattern_next = write_en ? symbol : pattern_reg;
    assign active       = (LEN_W'(INDEX) <= ctl.len_next);
    assign lead_out     = lead_in && active && (pattern_next == STAR_BYTE);

    always_comb begin
        if (pattern_reg == STAR_BYTE) begin
            adv = bit_reg | row_in;
        end else if (pattern_reg == ANY_BYTE || pattern_reg == symbol) begin
            adv = old_in;
        end else begin
            adv = 1'b0;
        end
    end

    always_comb begin
        priority if (ctl.load) begin
            bit_next = lead_out;
        end else if (ctl.step) begin
            bit_next = adv && active;
        end else begin
            bit_next = bit_reg;
        end
    end

    assign row_out = bit_next;
    assign old_out = bit_reg;

    always_ff @(posedge aclk) begin
        pattern_reg <= pattern_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= 1'b0;
        end else begin
            bit_reg <= bit_next;
        end
    end

endmodule

>>> hdl/wildcard_pattern_match.sv
// ---------------------------------------------------------------------------
// wildcard_pattern_match
// glob matcher: stored pattern with star and question mark, text streamed
// one byte per item, one registered result per item
// ---------------------------------------------------------------------------
// One item is taken every clock cycle and its result appears in the output
// register on the next cycle; a stalled result holds the input only while
// the output register stays full. Each item updates the match row as it is
// taken: the row is a chain of MAX_PATTERN cells, one per pattern byte, and
// the star runs and the leading-star row for a new text ripple through that
// chain, so the clock period grows with MAX_PATTERN. No clearing pass is
// needed after reset.
module wildcard_pattern_match
    import wpm_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // symbol[7:0]
    input  logic [1:0] s_tuser,   // kind[1:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // matched[0], overflow[1], zero[7:2]
);

`include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_PATTERN + 1);

    wpm_kind_t        kind;
    logic             accept;
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_next;
    logic             row0_reg;
    logic             row0_next;
    logic             load;
    logic             step;
    logic             wr;
    logic             ovf;
    wpm_ctl_t         ctl;
    logic             m_valid_reg;
    logic             matched_reg;
    logic             overflow_reg;

    logic [MAX_PATTERN:0] lead_vec;
    logic [MAX_PATTERN:0] row_vec;
    logic [MAX_PATTERN:0] old_vec;

    assign kind     = wpm_kind_t'(s_tuser);
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        load        = 1'b0;
        step        = 1'b0;
        wr          = 1'b0;
        ovf         = 1'b0;
        length_next = length_reg;
        if (accept) begin
            unique case (kind)
                KIND_CLEAR: begin
                    length_next = '0;
                    load        = 1'b1;
                end
                KIND_APPEND: begin
                    load = 1'b1;
                    if (length_reg < LEN_W'(MAX_PATTERN)) begin
                        wr          = 1'b1;
                        length_next = length_reg + LEN_W'(1);
                    end else begin
                        ovf = 1'b1;
                    end
                end
                KIND_BEGIN: begin
                    load = 1'b1;
                end
                KIND_TEXT: begin
                    step = 1'b1;
                end
                default: begin
                    load = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        priority if (load) begin
            row0_next = 1'b1;
        end else if (step) begin
            row0_next = 1'b0;
        end else begin
            row0_next = row0_reg;
        end
    end

    assign ctl.load     = load;
    assign ctl.step     = step;
    assign ctl.wr       = wr;
    assign ctl.len_cur  = length_reg;
    assign ctl.len_next = length_next;

    assign lead_vec[0] = 1'b1;
    assign row_vec[0]  = row0_next;
    assign old_vec[0]  = row0_reg;

    for (genvar g = 1; g <= MAX_PATTERN; g++) begin : g_cell
        wpm_cell #(
            .INDEX(g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .symbol  (s_tdata),
            .lead_in (lead_vec[g-1]),
            .row_in  (row_vec[g-1]),
            .old_in  (old_vec[g-1]),
            .lead_out(lead_vec[g]),
            .row_out (row_vec[g]),
            .old_out (old_vec[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg  <= '0;
            row0_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            length_reg <= length_next;
            row0_reg   <= row0_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            matched_reg  <= row_vec[length_next[IDX_W-1:0]];
            overflow_reg <= ovf;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, overflow_reg, matched_reg};

    `WPM_ASSERT_ALWAYS(a_len_range, length_reg <= LEN_W'(MAX_PATTERN))
    `WPM_ASSERT_ALWAYS(a_row_above_len, ((old_vec >> length_reg) >> 1) == '0)
    `WPM_ASSERT_IMPLIES(a_ovf_full, m_valid_reg && overflow_reg,
        length_reg == LEN_W'(MAX_PATTERN))
    `WPM_ASSERT_NEXT(a_empty_text, accept && kind == KIND_TEXT && length_reg == '0,
        !matched_reg && !row0_reg)
    `WPM_ASSERT_NEXT(a_begin_row0, accept && kind == KIND_BEGIN, row0_reg)

endmodule
